>>> rtl/core/opmt_pkg.sv
package opmt_pkg;

	localparam int VALUE_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 12;
	localparam int ACC_WIDTH_DEF   = 48;

	localparam int TILE      = 4;
	localparam int ENTRIES   = TILE * TILE;
	localparam int OP_W      = 2;
	localparam int INDEX_W   = $clog2(ENTRIES);
	localparam int ENTRY_W   = 48;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_UPDATE = 2'd1,
		OP_DRAIN  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DRAIN
	} state_t;

	// per-cycle controls shared by every cell of the chain
	typedef struct packed {
		logic mul_en;
		logic add_en;
		logic shift_en;
	} cell_ctl_t;

endpackage

>>> rtl/core/opmt_cmd_if.sv
interface opmt_cmd_if
	import opmt_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic        [OP_W-1:0]        operation;
	logic        [INDEX_W-1:0]     entry_index;
	logic signed [ENTRY_W-1:0]     entry_value;
	logic signed [VALUE_WIDTH-1:0] a_row0;
	logic signed [VALUE_WIDTH-1:0] a_row1;
	logic signed [VALUE_WIDTH-1:0] a_row2;
	logic signed [VALUE_WIDTH-1:0] a_row3;
	logic signed [VALUE_WIDTH-1:0] b_col0;
	logic signed [VALUE_WIDTH-1:0] b_col1;
	logic signed [VALUE_WIDTH-1:0] b_col2;
	logic signed [VALUE_WIDTH-1:0] b_col3;

	modport source (
		output valid, operation, entry_index, entry_value,
		output a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_index, entry_value,
		input  a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3,
		output ready
	);
endinterface

>>> rtl/core/opmt_res_if.sv
interface opmt_res_if
	import opmt_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic        [INDEX_W-1:0] out_index;
	logic signed [ENTRY_W-1:0] out_value;
	logic                      out_last;

	modport source (
		output valid, out_index, out_value, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_index, out_value, out_last,
		output ready
	);
endinterface

>>> rtl/core/outer_product_mac_tile_4x4.sv
// update: product register, then saturating add in every cell; one item at a time
// load: writes one addressed cell; drain: 16 items, one per cycle while the sink is ready,
// the chain of 16 accumulator cells rotating by one entry per emitted item
// an item is accepted again once the last drained entry sits in the output register
// reset (arst_n low, asynchronous) clears all accumulators and the control state
// throughput is set by the single control sequencer that owns the accumulator chain
module outer_product_mac_tile_4x4
	import opmt_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	opmt_cmd_if.sink   cmd,
	opmt_res_if.source res
);

	localparam int LD_W  = ((ACC_WIDTH > ENTRY_W) ? ACC_WIDTH : ENTRY_W) + 1;
	localparam int OUT_W = (ACC_WIDTH > ENTRY_W) ? ACC_WIDTH : ENTRY_W;

	localparam logic signed [LD_W-1:0] LD_MAX =
		LD_W'({1'b0, {(ACC_WIDTH-1){1'b1}}});
	localparam logic signed [LD_W-1:0] LD_MIN = ~LD_MAX;

	logic signed [VALUE_WIDTH-1:0] a_vec [TILE];
	logic signed [VALUE_WIDTH-1:0] b_vec [TILE];
	logic signed [ACC_WIDTH-1:0]   acc   [ENTRIES];
	logic signed [LD_W-1:0]        ld_ext;
	logic signed [ACC_WIDTH-1:0]   ld_value;
	logic signed [OUT_W-1:0]       head_ext;
	logic                          load_en;
	cell_ctl_t                     ctl;

	assign a_vec[0] = cmd.a_row0;
	assign a_vec[1] = cmd.a_row1;
	assign a_vec[2] = cmd.a_row2;
	assign a_vec[3] = cmd.a_row3;
	assign b_vec[0] = cmd.b_col0;
	assign b_vec[1] = cmd.b_col1;
	assign b_vec[2] = cmd.b_col2;
	assign b_vec[3] = cmd.b_col3;

	// loaded value saturates into the accumulator range
	assign ld_ext = LD_W'(cmd.entry_value);

	always_comb begin
		if (ld_ext > LD_MAX) begin
			ld_value = LD_MAX[ACC_WIDTH-1:0];
		end else if (ld_ext < LD_MIN) begin
			ld_value = LD_MIN[ACC_WIDTH-1:0];
		end else begin
			ld_value = ld_ext[ACC_WIDTH-1:0];
		end
	end

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		opmt_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.FRAC_BITS  (FRAC_BITS),
			.ACC_WIDTH  (ACC_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.load_en   (load_en && (cmd.entry_index == INDEX_W'(k))),
			.load_value(ld_value),
			.a         (a_vec[k / TILE]),
			.b         (b_vec[k % TILE]),
			.shift_in  (acc[(k + 1) % ENTRIES]),
			.acc       (acc[k])
		);
	end

	assign head_ext = OUT_W'(acc[0]);

	opmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.operation (cmd.operation),
		.cmd_ready (cmd.ready),
		.load_en   (load_en),
		.ctl       (ctl),
		.head_value(head_ext[ENTRY_W-1:0]),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.res_index (res.out_index),
		.res_value (res.out_value),
		.res_last  (res.out_last)
	);

endmodule

>>> rtl/core/opmt_cell.sv
module opmt_cell
	import opmt_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctl_t                     ctl,
	input  logic                          load_en,
	input  logic signed [ACC_WIDTH-1:0]   load_value,
	input  logic signed [VALUE_WIDTH-1:0] a,
	input  logic signed [VALUE_WIDTH-1:0] b,
	input  logic signed [ACC_WIDTH-1:0]   shift_in,
	output logic signed [ACC_WIDTH-1:0]   acc
);

	localparam int PROD_W = 2 * VALUE_WIDTH;
	localparam int SHR_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = ((SHR_W > ACC_WIDTH) ? SHR_W : ACC_WIDTH) + 1;

	localparam logic signed [SUM_W-1:0] ACC_MAX =
		SUM_W'({1'b0, {(ACC_WIDTH-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [SHR_W-1:0]     prod_shr;
	logic signed [SUM_W-1:0]     sum;
	logic signed [ACC_WIDTH-1:0] sum_sat;
	logic signed [ACC_WIDTH-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= a * b;
		end
	end

	// floor shift: dropping the low bits of a two's complement product
	assign prod_shr = $signed(prod_s1[PROD_W-1:FRAC_BITS]);
	assign sum      = SUM_W'(prod_shr) + SUM_W'(acc_q);

	always_comb begin
		if (sum > ACC_MAX) begin
			sum_sat = ACC_MAX[ACC_WIDTH-1:0];
		end else if (sum < ACC_MIN) begin
			sum_sat = ACC_MIN[ACC_WIDTH-1:0];
		end else begin
			sum_sat = sum[ACC_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (load_en) begin
			acc_q <= load_value;
		end else if (ctl.add_en) begin
			acc_q <= sum_sat;
		end else if (ctl.shift_en) begin
			acc_q <= shift_in;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/opmt_ctrl.sv
module opmt_ctrl
	import opmt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic [OP_W-1:0]           operation,
	output logic                      cmd_ready,
	output logic                      load_en,
	output cell_ctl_t                 ctl,
	input  logic signed [ENTRY_W-1:0] head_value,
	input  logic                      res_ready,
	output logic                      res_valid,
	output logic [INDEX_W-1:0]        res_index,
	output logic signed [ENTRY_W-1:0] res_value,
	output logic                      res_last
);

	localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(ENTRIES - 1);

	state_t                    state_q;
	state_t                    state_d;
	logic [INDEX_W-1:0]        cnt_q;
	logic                      out_valid_q;
	logic [INDEX_W-1:0]        out_index_q;
	logic signed [ENTRY_W-1:0] out_value_q;
	logic                      out_last_q;
	logic                      accept;
	logic                      take;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	// in drain, head of the chain moves into the output register when it is empty or the sink takes its entry
	assign take      = (state_q == ST_DRAIN) && (!out_valid_q || res_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_UPDATE: state_d = ST_ADD;
						OP_DRAIN:  state_d = ST_DRAIN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				state_d = ST_IDLE;
			end
			ST_DRAIN: begin
				if (take && cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		load_en      = accept && (operation == OP_LOAD);
		ctl.mul_en   = accept && (operation == OP_UPDATE);
		ctl.add_en   = (state_q == ST_ADD);
		ctl.shift_en = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				cnt_q       <= cnt_q + INDEX_W'(1);
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_index_q <= cnt_q;
			out_last_q  <= (cnt_q == LAST_IDX);
			out_value_q <= head_value;
		end
	end

	assign res_valid = out_valid_q;
	assign res_index = out_index_q;
	assign res_value = out_value_q;
	assign res_last  = out_last_q;

	a_mul_then_add: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul_en |=> ctl.add_en)
		else $error("update products not added in the following cycle");

	a_no_shift_during_add: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.add_en && (ctl.shift_en || load_en)))
		else $error("chain written by two sources at once");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		take && cnt_q == LAST_IDX |=> state_q == ST_IDLE && cnt_q == '0)
		else $error("drain did not end after the last entry");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_index_q == LAST_IDX)
		else $error("last mark on an entry other than the final one");

endmodule
